// File: hdl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types for the I2C master transaction sequencer: bus actions,
// error codes, the input item and the result item.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  // command codes of an input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // action requested from the byte engine
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_BEGIN   = 3'd4,
    ACT_READ    = 3'd5,
    ACT_STOP    = 3'd6
  } action_e;

  // transaction completion status
  typedef enum logic [1:0] {
    ERR_OK  = 2'd0,
    ERR_ARB = 2'd1,
    ERR_NAK = 2'd2
  } err_e;

  // one input word
  typedef struct packed {
    logic        cmd;
    logic [6:0]  slave_addr;
    logic [31:0] reg_addr;
    logic [2:0]  reg_addr_len;
    logic [15:0] tx_count;
    logic [15:0] rx_count;
    logic        arb_lost;
    logic        nak_seen;
    logic [7:0]  bus_rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  // one result word
  typedef struct packed {
    action_e     action;
    logic [7:0]  out_byte;
    logic        send_nack;
    logic        release_master;
    logic [7:0]  rx_data;
    logic        rx_valid;
    logic        done_res;
    err_e        error_code;
    logic [15:0] byte_count;
  } result_t;

endpackage

// File: hdl/i2cseq_core.sv
// ----------------------------------------------------------------------------
// i2cseq_core
// Transaction state and the per-word decision logic. The result is
// combinational from the current word and state; the state advances
// when step_i is high.
// ----------------------------------------------------------------------------
module i2cseq_core #(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int COUNT_BITS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2cseq_pkg::in_item_t item_i,
  output i2cseq_pkg::result_t  res_o
);

  localparam int AIW = (MAX_ADDR_BYTES > 1) ? $clog2(MAX_ADDR_BYTES) : 1;
  localparam logic [2:0] MAX_LEN = 3'(MAX_ADDR_BYTES);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_ONE = cnt_t'(1);

  // transaction state
  logic [6:0]                      target_q, target_d;
  logic [MAX_ADDR_BYTES-1:0][7:0]  addr_q, addr_d;
  logic [2:0]                      addr_left_q, addr_left_d;
  cnt_t                            tx_left_q, tx_left_d;
  cnt_t                            rx_left_q, rx_left_d;
  cnt_t                            tx_total_q, tx_total_d;
  cnt_t                            rx_total_q, rx_total_d;
  logic                            reading_q, reading_d;
  logic                            rx_started_q, rx_started_d;
  logic                            busy_q, busy_d;

  cnt_t       txc, rxc, rx_dec, done_cnt;
  logic [2:0] alen, addr_dec;
  logic       load_read;
  logic [AIW-1:0] addr_idx;

  // decoded start fields and helpers
  always_comb begin
    txc       = cnt_t'(item_i.tx_count);
    rxc       = cnt_t'(item_i.rx_count);
    alen      = (item_i.reg_addr_len > MAX_LEN) ? MAX_LEN : item_i.reg_addr_len;
    load_read = (alen == 3'd0) && (txc == '0);
    addr_dec  = addr_left_q - 3'd1;
    addr_idx  = addr_dec[AIW-1:0];
    rx_dec    = rx_left_q - CNT_ONE;
    done_cnt  = (rx_total_q != '0) ? (rx_total_q - rx_left_q) : (tx_total_q - tx_left_q);
  end

  // decision and next state
  always_comb begin
    res_o        = '0;
    target_d     = target_q;
    addr_d       = addr_q;
    addr_left_d  = addr_left_q;
    tx_left_d    = tx_left_q;
    rx_left_d    = rx_left_q;
    tx_total_d   = tx_total_q;
    rx_total_d   = rx_total_q;
    reading_d    = reading_q;
    rx_started_d = rx_started_q;
    busy_d       = busy_q;
    if (item_i.cmd == i2cseq_pkg::CMD_START) begin
      if (txc == '0 && rxc == '0) begin
        // nothing to transfer, finish without touching the bus
        busy_d         = 1'b0;
        res_o.done_res = 1'b1;
      end else begin
        target_d       = item_i.slave_addr;
        addr_d         = item_i.reg_addr[8*MAX_ADDR_BYTES-1:0];
        addr_left_d    = alen;
        tx_left_d      = txc;
        tx_total_d     = txc;
        rx_left_d      = rxc;
        rx_total_d     = rxc;
        reading_d      = load_read;
        rx_started_d   = 1'b0;
        busy_d         = 1'b1;
        res_o.action   = i2cseq_pkg::ACT_START;
        res_o.out_byte = {item_i.slave_addr, load_read};
      end
    end else if (busy_q) begin
      if (item_i.arb_lost) begin
        busy_d               = 1'b0;
        res_o.action         = i2cseq_pkg::ACT_STOP;
        res_o.release_master = 1'b1;
        res_o.done_res       = 1'b1;
        res_o.error_code     = i2cseq_pkg::ERR_ARB;
      end else if (item_i.nak_seen && rx_left_q != CNT_ONE) begin
        busy_d               = 1'b0;
        res_o.action         = i2cseq_pkg::ACT_STOP;
        res_o.release_master = 1'b1;
        res_o.done_res       = 1'b1;
        res_o.error_code     = i2cseq_pkg::ERR_NAK;
      end else if (addr_left_q != 3'd0) begin
        // register address, most significant byte first
        res_o.action   = i2cseq_pkg::ACT_WRITE;
        res_o.out_byte = addr_q[addr_idx];
        addr_left_d    = addr_dec;
      end else if (tx_left_q != '0) begin
        res_o.action   = i2cseq_pkg::ACT_WRITE;
        res_o.out_byte = item_i.tx_byte;
        tx_left_d      = tx_left_q - CNT_ONE;
      end else if (rx_left_q != '0) begin
        if (!reading_q) begin
          res_o.action   = i2cseq_pkg::ACT_RESTART;
          res_o.out_byte = {target_q, 1'b1};
          reading_d      = 1'b1;
          rx_started_d   = 1'b0;
        end else if (!rx_started_q) begin
          // dummy read kicks off reception
          res_o.action    = i2cseq_pkg::ACT_BEGIN;
          res_o.send_nack = (rx_left_q == CNT_ONE);
          rx_started_d    = 1'b1;
        end else begin
          res_o.action         = i2cseq_pkg::ACT_READ;
          res_o.rx_data        = item_i.bus_rx_byte;
          res_o.rx_valid       = 1'b1;
          res_o.release_master = (rx_left_q == CNT_ONE);
          res_o.send_nack      = (rx_dec == CNT_ONE);
          rx_left_d            = rx_dec;
          if (rx_dec == '0) begin
            busy_d           = 1'b0;
            res_o.done_res   = 1'b1;
            res_o.byte_count = 16'(rx_total_q);
          end
        end
      end else begin
        // nothing left, normal stop
        busy_d               = 1'b0;
        res_o.action         = i2cseq_pkg::ACT_STOP;
        res_o.release_master = 1'b1;
        res_o.done_res       = 1'b1;
        res_o.error_code     = i2cseq_pkg::ERR_OK;
        res_o.byte_count     = 16'(done_cnt);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      addr_q       <= '0;
      addr_left_q  <= '0;
      tx_left_q    <= '0;
      rx_left_q    <= '0;
      tx_total_q   <= '0;
      rx_total_q   <= '0;
      reading_q    <= 1'b0;
      rx_started_q <= 1'b0;
      busy_q       <= 1'b0;
    end else if (step_i) begin
      target_q     <= target_d;
      addr_q       <= addr_d;
      addr_left_q  <= addr_left_d;
      tx_left_q    <= tx_left_d;
      rx_left_q    <= rx_left_d;
      tx_total_q   <= tx_total_d;
      rx_total_q   <= rx_total_d;
      reading_q    <= reading_d;
      rx_started_q <= rx_started_d;
      busy_q       <= busy_d;
    end
  end

`ifndef SYNTHESIS
  // address bytes never run past the configured maximum
  a_addr_left_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    addr_left_q <= MAX_LEN)
    else $error("address byte count above maximum");

  // remaining receive count never exceeds the loaded total
  a_rx_left_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_left_q <= rx_total_q)
    else $error("receive count above total");

  // reception only begins after the read direction is set
  a_started_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_started_q |-> reading_q)
    else $error("reception started while writing");
`endif

endmodule

// File: hdl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Drives one I2C master transaction over a byte-level engine: START,
// register-address and data writes, repeated START, reception and STOP.
//
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   cmd_i .. tx_byte_i
//   out       out_valid_o / out_ready_i action_o .. byte_count_o
//
// One word is taken per cycle while the result side is not stalled; after
// acceptance it passes through the input register, the decision logic and the
// result register, where its result is presented until it is taken.
// Reset clears the transaction state and both valid flags.
// A stalled result holds the pipe; a new word is still taken into the
// input register while it is empty or advancing.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int COUNT_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [6:0]  slave_addr_i,
  input  logic [31:0] reg_addr_i,
  input  logic [2:0]  reg_addr_len_i,
  input  logic [15:0] tx_count_i,
  input  logic [15:0] rx_count_i,
  input  logic        arb_lost_i,
  input  logic        nak_seen_i,
  input  logic [7:0]  bus_rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [7:0]  out_byte_o,
  output logic        send_nack_o,
  output logic        release_master_o,
  output logic [7:0]  rx_data_o,
  output logic        rx_valid_o,
  output logic        done_res_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] byte_count_o
);

  logic                 in_valid_q;
  i2cseq_pkg::in_item_t in_q;
  logic                 out_valid_q;
  i2cseq_pkg::result_t  res_q, res_d;
  logic                 advance;

  // pipe control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.cmd          <= cmd_i;
      in_q.slave_addr   <= slave_addr_i;
      in_q.reg_addr     <= reg_addr_i;
      in_q.reg_addr_len <= reg_addr_len_i;
      in_q.tx_count     <= tx_count_i;
      in_q.rx_count     <= rx_count_i;
      in_q.arb_lost     <= arb_lost_i;
      in_q.nak_seen     <= nak_seen_i;
      in_q.bus_rx_byte  <= bus_rx_byte_i;
      in_q.tx_byte      <= tx_byte_i;
    end
  end

  // sequencing decision
  i2cseq_core #(
    .MAX_ADDR_BYTES(MAX_ADDR_BYTES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_q),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o      = out_valid_q;
  assign action_o         = res_q.action;
  assign out_byte_o       = res_q.out_byte;
  assign send_nack_o      = res_q.send_nack;
  assign release_master_o = res_q.release_master;
  assign rx_data_o        = res_q.rx_data;
  assign rx_valid_o       = res_q.rx_valid;
  assign done_res_o       = res_q.done_res;
  assign error_code_o     = res_q.error_code;
  assign byte_count_o     = res_q.byte_count;

`ifndef SYNTHESIS
  // a delivered byte only comes with a read action
  a_rx_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> action_o == i2cseq_pkg::ACT_READ)
    else $error("received byte without read action");

  // leaving master mode always closes the transaction
  a_release_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_master_o |-> done_res_o)
    else $error("master released without completion");

  // an error ends with stop and no byte count
  a_err_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != i2cseq_pkg::ERR_OK
      |-> action_o == i2cseq_pkg::ACT_STOP && byte_count_o == 16'd0)
    else $error("error result without stop");

  // a stalled result keeps the input word waiting
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_q |=> in_valid_q)
    else $error("input word lost during stall");
`endif

endmodule

// File: bench/i2cseq_checker.sv
// ----------------------------------------------------------------------------
// i2cseq_checker
// Watches both channels of the transaction sequencer, predicts the result
// of every accepted word from its own copy of the transaction state, and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module i2cseq_checker #(
  parameter int MAX_ADDR_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [6:0]  slave_addr_i,
  input  logic [31:0] reg_addr_i,
  input  logic [2:0]  reg_addr_len_i,
  input  logic [15:0] tx_count_i,
  input  logic [15:0] rx_count_i,
  input  logic        arb_lost_i,
  input  logic        nak_seen_i,
  input  logic [7:0]  bus_rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  out_byte_i,
  input  logic        send_nack_i,
  input  logic        release_master_i,
  input  logic [7:0]  rx_data_i,
  input  logic        rx_valid_i,
  input  logic        done_res_i,
  input  logic [1:0]  error_code_i,
  input  logic [15:0] byte_count_i,
  // status for the top
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the transaction state
  logic [6:0]  target_addr = '0;
  logic [31:0] addr_shift  = '0;
  logic [2:0]  addr_left   = '0;
  logic [15:0] tx_left     = '0;
  logic [15:0] rx_left     = '0;
  logic [15:0] tx_total    = '0;
  logic [15:0] rx_total    = '0;
  logic        reading     = 1'b0;
  logic        rx_started  = 1'b0;
  logic        busy        = 1'b0;

  i2cseq_pkg::result_t bus_results_due[$];
  int                  mismatches = 0;

  // end the transaction with stop and the given status
  function automatic i2cseq_pkg::result_t close_with_stop(i2cseq_pkg::err_e err);
    i2cseq_pkg::result_t r;
    r = '0;
    busy = 1'b0;
    r.action = i2cseq_pkg::ACT_STOP;
    r.release_master = 1'b1;
    r.done_res = 1'b1;
    r.error_code = err;
    if (err == i2cseq_pkg::ERR_OK) begin
      r.byte_count = (rx_total != '0) ? rx_total - rx_left : tx_total - tx_left;
    end
    return r;
  endfunction

  // result of one word, advancing the shadow state
  function automatic i2cseq_pkg::result_t next_bus_result(i2cseq_pkg::in_item_t w);
    i2cseq_pkg::result_t r;
    logic [2:0]          alen;
    r = '0;
    if (w.cmd == i2cseq_pkg::CMD_START) begin
      if (w.tx_count == '0 && w.rx_count == '0) begin
        // nothing to move: finish at once without touching the bus
        busy = 1'b0;
        r.done_res = 1'b1;
      end else begin
        alen = (w.reg_addr_len > MAX_ADDR_BYTES) ? 3'(MAX_ADDR_BYTES) : w.reg_addr_len;
        target_addr = w.slave_addr;
        addr_shift  = w.reg_addr;
        addr_left   = alen;
        tx_left     = w.tx_count;
        tx_total    = w.tx_count;
        rx_left     = w.rx_count;
        rx_total    = w.rx_count;
        reading     = (alen == '0 && w.tx_count == '0);
        rx_started  = 1'b0;
        busy        = 1'b1;
        r.action    = i2cseq_pkg::ACT_START;
        r.out_byte  = {w.slave_addr, reading};
      end
    end else if (!busy) begin
      // byte event with no transaction running yields an empty result
    end else if (w.arb_lost) begin
      r = close_with_stop(i2cseq_pkg::ERR_ARB);
    end else if (w.nak_seen && rx_left != 16'd1) begin
      r = close_with_stop(i2cseq_pkg::ERR_NAK);
    end else if (addr_left != '0) begin
      // register address, most significant byte first
      r.action = i2cseq_pkg::ACT_WRITE;
      r.out_byte = addr_shift[8 * (addr_left - 1) +: 8];
      addr_left--;
    end else if (tx_left != '0) begin
      r.action = i2cseq_pkg::ACT_WRITE;
      r.out_byte = w.tx_byte;
      tx_left--;
    end else if (rx_left != '0) begin
      if (!reading) begin
        r.action = i2cseq_pkg::ACT_RESTART;
        r.out_byte = {target_addr, 1'b1};
        reading = 1'b1;
        rx_started = 1'b0;
      end else if (!rx_started) begin
        // dummy read kicks off reception
        r.action = i2cseq_pkg::ACT_BEGIN;
        rx_started = 1'b1;
        r.send_nack = (rx_left == 16'd1);
      end else begin
        r.action = i2cseq_pkg::ACT_READ;
        r.rx_data = w.bus_rx_byte;
        r.rx_valid = 1'b1;
        r.release_master = (rx_left == 16'd1);
        rx_left--;
        r.send_nack = (rx_left == 16'd1);
        if (rx_left == '0) begin
          busy = 1'b0;
          r.done_res = 1'b1;
          r.byte_count = rx_total;
        end
      end
    end else begin
      r = close_with_stop(i2cseq_pkg::ERR_OK);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare results, then predict the word taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    i2cseq_pkg::result_t  want;
    i2cseq_pkg::in_item_t word;
    if (!rst_ni) begin
      target_addr = '0;
      addr_shift  = '0;
      addr_left   = '0;
      tx_left     = '0;
      rx_left     = '0;
      tx_total    = '0;
      rx_total    = '0;
      reading     = 1'b0;
      rx_started  = 1'b0;
      busy        = 1'b0;
      bus_results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (bus_results_due.size() == 0) begin
          $display("%0t: result with none expected, actual action %0d byte %0h done %0b",
                   $time, action_i, out_byte_i, done_res_i);
          mismatches++;
        end else begin
          want = bus_results_due.pop_front();
          check_field("action", want.action, action_i);
          check_field("out_byte", want.out_byte, out_byte_i);
          check_field("send_nack", want.send_nack, send_nack_i);
          check_field("release_master", want.release_master, release_master_i);
          check_field("rx_data", want.rx_data, rx_data_i);
          check_field("rx_valid", want.rx_valid, rx_valid_i);
          check_field("done_res", want.done_res, done_res_i);
          check_field("error_code", want.error_code, error_code_i);
          check_field("byte_count", want.byte_count, byte_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        word.cmd          = cmd_i;
        word.slave_addr   = slave_addr_i;
        word.reg_addr     = reg_addr_i;
        word.reg_addr_len = reg_addr_len_i;
        word.tx_count     = tx_count_i;
        word.rx_count     = rx_count_i;
        word.arb_lost     = arb_lost_i;
        word.nak_seen     = nak_seen_i;
        word.bus_rx_byte  = bus_rx_byte_i;
        word.tx_byte      = tx_byte_i;
        bus_results_due.push_back(next_bus_result(word));
      end
    end
    fail_count_o <= mismatches;
    pending_o <= bus_results_due.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the I2C master transaction sequencer: directed transactions
// covering the corner cases, then random well-formed transactions with
// injected errors, replacements and stray events, under several idle and
// stall patterns. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ADDR_BYTES  = 4;
  localparam int QUIET_LIMIT     = 2000;
  localparam int WORDS_PER_PHASE = 115;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [6:0]  slave_addr_i;
  logic [31:0] reg_addr_i;
  logic [2:0]  reg_addr_len_i;
  logic [15:0] tx_count_i;
  logic [15:0] rx_count_i;
  logic        arb_lost_i;
  logic        nak_seen_i;
  logic [7:0]  bus_rx_byte_i;
  logic [7:0]  tx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  action_o;
  logic [7:0]  out_byte_o;
  logic        send_nack_o;
  logic        release_master_o;
  logic [7:0]  rx_data_o;
  logic        rx_valid_o;
  logic        done_res_o;
  logic [1:0]  error_code_o;
  logic [15:0] byte_count_o;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int err_pct   = 0;
  int words_sent = 0;

  i2c_master_transaction_sequencer #(
    .MAX_ADDR_BYTES(MAX_ADDR_BYTES),
    .COUNT_BITS    (16)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .slave_addr_i    (slave_addr_i),
    .reg_addr_i      (reg_addr_i),
    .reg_addr_len_i  (reg_addr_len_i),
    .tx_count_i      (tx_count_i),
    .rx_count_i      (rx_count_i),
    .arb_lost_i      (arb_lost_i),
    .nak_seen_i      (nak_seen_i),
    .bus_rx_byte_i   (bus_rx_byte_i),
    .tx_byte_i       (tx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .out_byte_o      (out_byte_o),
    .send_nack_o     (send_nack_o),
    .release_master_o(release_master_o),
    .rx_data_o       (rx_data_o),
    .rx_valid_o      (rx_valid_o),
    .done_res_o      (done_res_o),
    .error_code_o    (error_code_o),
    .byte_count_o    (byte_count_o)
  );

  i2cseq_checker #(
    .MAX_ADDR_BYTES(MAX_ADDR_BYTES)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .slave_addr_i    (slave_addr_i),
    .reg_addr_i      (reg_addr_i),
    .reg_addr_len_i  (reg_addr_len_i),
    .tx_count_i      (tx_count_i),
    .rx_count_i      (rx_count_i),
    .arb_lost_i      (arb_lost_i),
    .nak_seen_i      (nak_seen_i),
    .bus_rx_byte_i   (bus_rx_byte_i),
    .tx_byte_i       (tx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_i        (action_o),
    .out_byte_i      (out_byte_o),
    .send_nack_i     (send_nack_o),
    .release_master_i(release_master_o),
    .rx_data_i       (rx_data_o),
    .rx_valid_i      (rx_valid_o),
    .done_res_i      (done_res_o),
    .error_code_i    (error_code_o),
    .byte_count_i    (byte_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // byte events a well-formed transaction takes to finish
  function automatic int event_total(int alen, int tx, int rx);
    int a;
    a = (alen > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES : alen;
    if (tx == 0 && rx == 0) return 0;
    if (rx == 0) return a + tx + 1;
    if (a == 0 && tx == 0) return rx + 1;
    return a + tx + rx + 2;
  endfunction

  // word with every field random
  function automatic i2cseq_pkg::in_item_t random_word();
    i2cseq_pkg::in_item_t w;
    w.cmd          = 1'($urandom_range(1));
    w.slave_addr   = 7'($urandom_range(127));
    w.reg_addr     = $urandom();
    w.reg_addr_len = 3'($urandom_range(7));
    w.tx_count     = 16'($urandom_range(65535));
    w.rx_count     = 16'($urandom_range(65535));
    w.arb_lost     = 1'($urandom_range(1));
    w.nak_seen     = 1'($urandom_range(1));
    w.bus_rx_byte  = 8'($urandom_range(255));
    w.tx_byte      = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic i2cseq_pkg::in_item_t start_word(logic [6:0] slave, logic [31:0] addr,
                                                      logic [2:0] alen, logic [15:0] tx,
                                                      logic [15:0] rx);
    i2cseq_pkg::in_item_t w;
    w = random_word();
    w.cmd          = i2cseq_pkg::CMD_START;
    w.slave_addr   = slave;
    w.reg_addr     = addr;
    w.reg_addr_len = alen;
    w.tx_count     = tx;
    w.rx_count     = rx;
    return w;
  endfunction

  function automatic i2cseq_pkg::in_item_t event_word(logic arb, logic nak);
    i2cseq_pkg::in_item_t w;
    w = random_word();
    w.cmd      = i2cseq_pkg::CMD_EVENT;
    w.arb_lost = arb;
    w.nak_seen = nak;
    return w;
  endfunction

  // drive one word and hold it until taken
  task automatic send_word(i2cseq_pkg::in_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= w.cmd;
    slave_addr_i   <= w.slave_addr;
    reg_addr_i     <= w.reg_addr;
    reg_addr_len_i <= w.reg_addr_len;
    tx_count_i     <= w.tx_count;
    rx_count_i     <= w.rx_count;
    arb_lost_i     <= w.arb_lost;
    nak_seen_i     <= w.nak_seen;
    bus_rx_byte_i  <= w.bus_rx_byte;
    tx_byte_i      <= w.tx_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // start word then its byte events; cut short to leave it running
  task automatic run_transaction(i2cseq_pkg::in_item_t sw, int cut, bit last_nak);
    int  total;
    int  sent;
    int  k;
    bit  last;
    bit  nak_ok;
    bit  arb;
    bit  nak;
    total = event_total(sw.reg_addr_len, sw.tx_count, sw.rx_count);
    sent = (cut >= 0 && cut < total) ? cut : total;
    send_word(sw);
    for (k = 0; k < sent; k++) begin
      last = (k == total - 1);
      // a nak is expected while exactly one byte is left to receive
      nak_ok = (sw.rx_count == 16'd1) || (last && sw.rx_count != '0);
      arb = ($urandom_range(99) < err_pct);
      nak = ($urandom_range(99) < err_pct) || (last && last_nak);
      send_word(event_word(arb, nak));
      if (arb || (nak && !nak_ok)) break;
    end
  endtask

  task automatic random_transaction();
    int         pick;
    logic [2:0] alen;
    int         tx;
    int         rx;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // stray event, often with no transaction running
      send_word(event_word(1'($urandom_range(1)), 1'($urandom_range(1))));
      words_sent--;
    end else if (pick < 10) begin
      run_transaction(start_word(7'($urandom_range(127)), $urandom(),
                                 3'($urandom_range(7)), '0, '0), -1, 1'b0);
    end else if (pick < 18) begin
      // huge counts, abandoned early by an error or the next start
      run_transaction(start_word(7'($urandom_range(127)), $urandom(),
                                 3'($urandom_range(7)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535))),
                      $urandom_range(4), 1'b0);
    end else begin
      alen = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
      tx = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4);
      rx = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4);
      run_transaction(start_word(7'($urandom_range(127)), $urandom(), alen,
                                 16'(tx), 16'(rx)),
                      ($urandom_range(9) == 0) ? $urandom_range(6) : -1,
                      ($urandom_range(9) < 3));
    end
  endtask

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** i2c_master_transaction_sequencer: FAILED **");
    $finish;
  end

  initial begin
    int ph;
    int target;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    cmd_i          = 1'b0;
    slave_addr_i   = '0;
    reg_addr_i     = '0;
    reg_addr_len_i = '0;
    tx_count_i     = '0;
    rx_count_i     = '0;
    arb_lost_i     = 1'b0;
    nak_seen_i     = 1'b0;
    bus_rx_byte_i  = '0;
    tx_byte_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray event while idle
    send_word(event_word(1'b1, 1'b1));
    // nothing to transfer
    run_transaction(start_word(7'h55, '0, 3'd0, '0, '0), -1, 1'b0);
    // too many address bytes, write then read, expected nak on the last byte
    run_transaction(start_word(7'h7F, 32'hFFFF_FFFF, 3'd7, 16'd1, 16'd1), -1, 1'b1);
    // read only from the first start
    run_transaction(start_word(7'h00, 32'h0000_0000, 3'd0, 16'd0, 16'd2), -1, 1'b1);
    // one address byte, one data byte, normal stop
    run_transaction(start_word(7'h2A, 32'h1234_5678, 3'd1, 16'd1, 16'd0), -1, 1'b0);
    // arbitration loss beats nak
    send_word(start_word(7'h7F, $urandom(), 3'd2, 16'hFFFF, 16'hFFFF));
    send_word(event_word(1'b1, 1'b1));
    // unexpected nak while writing
    send_word(start_word(7'h01, $urandom(), 3'd0, 16'd2, 16'd0));
    send_word(event_word(1'b0, 1'b1));
    // start while busy replaces the running transaction
    send_word(start_word(7'h33, $urandom(), 3'd3, 16'd0, 16'd3));
    send_word(start_word(7'h10, $urandom(), 3'd4, 16'd0, 16'd0));

    // random: free flow, sender idle, receiver stall, both
    err_pct = 3;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 17 : 0;
      stall_pct = (ph == 2) ? 84 : (ph == 3) ? 17 : 0;
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) random_transaction();
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;

    // drain outstanding results
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** i2c_master_transaction_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_transaction_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
